// ===== design/lpfw_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfw_pkg
// Shared types, constants and the LED-to-colour map for the LED PWM frame
// word generator.
// ----------------------------------------------------------------------------
package lpfw_pkg;

    localparam int CHIP_COUNT_DEF = 2;
    localparam int SLOT_COUNT     = 255;
    localparam int LED_COUNT      = 7;
    localparam int CH_PER_CHIP    = 16;
    localparam int USED_CH        = 3 * LED_COUNT;
    localparam int LED_W          = 3;
    localparam int COLOUR_W       = 24;

    typedef enum logic [1:0] {
        OP_STORE   = 2'd0,
        OP_PRESENT = 2'd1,
        OP_FETCH   = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_FETCH   = 3'b010,
        ST_PRESENT = 3'b100
    } t_state;

    typedef enum logic [1:0] {
        PART_BLUE  = 2'd0,
        PART_RED   = 2'd1,
        PART_GREEN = 2'd2
    } t_part;

    // stored LED that feeds output LED i
    function automatic logic [LED_W-1:0] led_map(input logic [LED_W-1:0] i);
        logic [LED_W-1:0] m;
        case (i)
            3'd0:    m = 3'd0;
            3'd1:    m = 3'd1;
            3'd2:    m = 3'd3;
            3'd3:    m = 3'd5;
            3'd4:    m = 3'd6;
            3'd5:    m = 3'd2;
            3'd6:    m = 3'd4;
            default: m = 3'd0;
        endcase
        return m;
    endfunction

endpackage

// ===== design/lpfw_bank_ram.sv =====
// ----------------------------------------------------------------------------
// lpfw_bank_ram
// Two brightness banks, one row of sixteen channel bytes per chip. Byte-wide
// write, whole-row registered read. Rows never written read as zero.
// ----------------------------------------------------------------------------
module lpfw_bank_ram
    import lpfw_pkg::*;
#(
    parameter int CHIP_COUNT = CHIP_COUNT_DEF,
    localparam int ROWS  = 2 * CHIP_COUNT,
    localparam int ROW_W = $clog2(ROWS)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_en,
    input  logic [ROW_W-1:0]                i_wr_row,
    input  logic [3:0]                      i_wr_byte,
    input  logic [7:0]                      i_wr_data,
    input  logic                            i_rd_en,
    input  logic [ROW_W-1:0]                i_rd_row,
    output logic [CH_PER_CHIP-1:0][7:0]     o_rd_data
);

    logic [CH_PER_CHIP-1:0][7:0] r_mem [ROWS];
    logic [ROWS-1:0]             r_row_vld;
    logic [CH_PER_CHIP-1:0][7:0] r_rd_data;
    logic                        r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_row][i_wr_byte] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_ok   <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_vld[i_wr_row] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= r_row_vld[i_rd_row];
            end
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

// ===== design/led_pwm_frame_word_generator.sv =====
// ----------------------------------------------------------------------------
// led_pwm_frame_word_generator
// Thermometer-coded, active-low PWM shift-out words for a chain of
// sixteen-channel LED driver chips, double-buffered picture banks.
//
//  channel   dir  tdata (low bit up)                         tuser / tlast
//  s_axis    in   led_index[2:0] red[10:3] green[18:11]      tuser: opcode
//                 blue[26:19], zero pad to 32
//  m_axis    out  drive_word[15:0]                           tlast: frame_end
//                                                            tuser: bank_switched
//
// A store beat writes the colour store. A fetch beat does a bank row read,
// then the compare; the result register frees the input side, a stalled word
// holds the next fetch in its compare cycle. A present beat sweeps one channel
// byte per cycle through the colour store read port.
// Synchronous active-low reset; all stores read zero after reset.
// ----------------------------------------------------------------------------
module led_pwm_frame_word_generator
    import lpfw_pkg::*;
#(
    parameter int CHIP_COUNT = CHIP_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // led_index, red, green, blue
    input  logic [1:0]  i_s_axis_tuser,   // opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // drive_word
    output logic        o_m_axis_tlast,   // frame_end
    output logic [0:0]  o_m_axis_tuser    // bank_switched
);

    localparam int NCH   = CH_PER_CHIP * CHIP_COUNT;
    localparam int CHW   = $clog2(NCH);
    localparam int CW    = $clog2(CHIP_COUNT);
    localparam int ROWS  = 2 * CHIP_COUNT;
    localparam int ROW_W = $clog2(ROWS);

    t_state             r_state;
    logic               r_active;
    logic               r_ready;
    logic [7:0]         r_slot;
    logic [CW-1:0]      r_pos;

    logic [COLOUR_W-1:0] r_col_mem [LED_COUNT];
    logic [LED_COUNT-1:0] r_col_vld;
    logic [COLOUR_W-1:0] r_col_rd;
    logic               r_col_ok;

    logic [CHW-1:0]     r_ch;
    logic [LED_W-1:0]   r_led;
    t_part              r_part;
    logic               r_issue;
    logic               r_p_vld;
    logic [CHW-1:0]     r_p_ch;
    t_part              r_p_part;
    logic               r_p_used;

    logic               r_out_vld;
    logic [15:0]        r_out_word;
    logic               r_out_last;
    logic               r_out_sw;

    logic               w_accept;
    t_opcode            w_op;
    logic [LED_W-1:0]   w_idx;
    logic [COLOUR_W-1:0] w_colour;
    logic               w_out_free;
    logic [CW-1:0]      w_chip;
    logic               w_rd_en;
    logic [ROW_W-1:0]   w_rd_row;
    logic [ROW_W-1:0]   w_wr_row;
    logic [7:0]         w_wr_data;
    logic [COLOUR_W-1:0] w_col;
    logic [CH_PER_CHIP-1:0][7:0] w_row;
    logic [15:0]        w_word;
    logic               w_slot_end;
    logic               w_frame_end;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_op     = t_opcode'(i_s_axis_tuser);
    assign w_idx    = i_s_axis_tdata[2:0];
    assign w_colour = {i_s_axis_tdata[10:3], i_s_axis_tdata[18:11], i_s_axis_tdata[26:19]};

    assign w_out_free = !r_out_vld || i_m_axis_tready;

    // bank row read for a fetch
    assign w_chip   = CW'(CHIP_COUNT - 1) - r_pos;
    assign w_rd_en  = w_accept && (w_op == OP_FETCH);
    assign w_rd_row = (r_active ? ROW_W'(CHIP_COUNT) : '0) + ROW_W'(w_chip);

    // present sweep: write into the idle bank
    assign w_wr_row = (r_active ? '0 : ROW_W'(CHIP_COUNT)) + ROW_W'(r_p_ch[CHW-1:4]);
    assign w_col    = r_col_ok ? r_col_rd : '0;

    always_comb begin
        w_wr_data = '0;
        if (r_p_used) begin
            case (r_p_part)
                PART_BLUE:  w_wr_data = w_col[7:0];
                PART_RED:   w_wr_data = w_col[23:16];
                PART_GREEN: w_wr_data = w_col[15:8];
                default:    w_wr_data = '0;
            endcase
        end
    end

    lpfw_bank_ram #(
        .CHIP_COUNT (CHIP_COUNT)
    ) u_bank_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (r_p_vld),
        .i_wr_row  (w_wr_row),
        .i_wr_byte (r_p_ch[3:0]),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_row  (w_rd_row),
        .o_rd_data (w_row)
    );

    always_comb begin
        for (int k = 0; k < CH_PER_CHIP; k++) begin
            w_word[k] = !(w_row[k] >= r_slot);
        end
    end

    assign w_slot_end  = (r_pos == CW'(CHIP_COUNT - 1));
    assign w_frame_end = w_slot_end && (r_slot == 8'(SLOT_COUNT));

    // colour store
    always_ff @(posedge i_clk) begin
        if (w_accept && (w_op == OP_STORE) && (w_idx < LED_W'(LED_COUNT))) begin
            r_col_mem[w_idx] <= w_colour;
        end
        if (r_state == ST_PRESENT) begin
            r_col_rd <= r_col_mem[led_map(r_led)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_PRESENT && r_issue) begin
            r_p_ch   <= r_ch;
            r_p_part <= r_part;
            r_p_used <= (r_ch < CHW'(USED_CH));
        end
        if (r_state == ST_FETCH && w_out_free) begin
            r_out_word <= w_word;
            r_out_last <= w_frame_end;
            r_out_sw   <= w_frame_end && r_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_active  <= 1'b0;
            r_ready   <= 1'b0;
            r_slot    <= 8'd1;
            r_pos     <= '0;
            r_col_vld <= '0;
            r_col_ok  <= 1'b0;
            r_ch      <= '0;
            r_led     <= '0;
            r_part    <= PART_BLUE;
            r_issue   <= 1'b0;
            r_p_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_state == ST_FETCH && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        case (w_op)
                            OP_STORE: begin
                                if (w_idx < LED_W'(LED_COUNT)) begin
                                    r_col_vld[w_idx] <= 1'b1;
                                end
                            end
                            OP_PRESENT: begin
                                r_state <= ST_PRESENT;
                                r_ch    <= '0;
                                r_led   <= '0;
                                r_part  <= PART_BLUE;
                                r_issue <= 1'b1;
                                r_p_vld <= 1'b0;
                            end
                            OP_FETCH: begin
                                r_state <= ST_FETCH;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_FETCH: begin
                    if (w_out_free) begin
                        r_state   <= ST_IDLE;
                        if (w_slot_end) begin
                            r_pos <= '0;
                            if (w_frame_end) begin
                                r_slot <= 8'd1;
                                if (r_ready) begin
                                    r_active <= !r_active;
                                    r_ready  <= 1'b0;
                                end
                            end else begin
                                r_slot <= r_slot + 8'd1;
                            end
                        end else begin
                            r_pos <= r_pos + CW'(1);
                        end
                    end
                end
                ST_PRESENT: begin
                    r_p_vld <= r_issue;
                    if (r_issue) begin
                        r_col_ok <= r_col_vld[led_map(r_led)];
                        r_ch     <= r_ch + CHW'(1);
                        if (r_part == PART_GREEN) begin
                            r_part <= PART_BLUE;
                            r_led  <= r_led + LED_W'(1);
                        end else begin
                            r_part <= t_part'(r_part + 2'd1);
                        end
                        if (r_ch == CHW'(NCH - 1)) begin
                            r_issue <= 1'b0;
                        end
                    end
                    if (!r_issue && r_p_vld) begin
                        r_state <= ST_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid   = r_out_vld;
    assign o_m_axis_tdata    = r_out_word;
    assign o_m_axis_tlast    = r_out_last;
    assign o_m_axis_tuser[0] = r_out_sw;

    a_switch_on_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (!o_m_axis_tuser[0] || o_m_axis_tlast))
        else $error("bank switch flagged off a frame end");

    a_fetch_enters_compare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op == OP_FETCH) |=> (r_state == ST_FETCH))
        else $error("fetch beat did not reach the compare cycle");

    a_ready_clears_by_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(r_ready) && $past(i_rst_n)) |-> (r_active != $past(r_active)))
        else $error("ready picture dropped without a bank switch");

    a_no_write_outside_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_vld |-> (r_state == ST_PRESENT))
        else $error("bank write outside a present sweep");

endmodule
